@@ src/ssd_pkg.sv @@
// Package with the mode codes, field widths and glyph tables of the status digit.
`default_nettype none
package ssd_pkg;

  localparam int unsigned ValueW  = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned SegW    = 8;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned LetterCount = 9;
  localparam logic [ValueW-1:0] BatteryLimit = 5'd10;

  typedef enum logic [1:0] {
    MODE_SET_ERROR   = 2'd0,
    MODE_CLEAR_ERROR = 2'd1,
    MODE_SET_BATTERY = 2'd2,
    MODE_UNUSED      = 2'd3
  } mode_t;

  function automatic logic [SegW-1:0] digit_glyph(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'hFC;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hDA;
      4'd3:    seg = 8'hF2;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'hB6;
      4'd6:    seg = 8'hBE;
      4'd7:    seg = 8'hE0;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hF6;
      default: seg = 8'hFC;
    endcase
    return seg;
  endfunction

  // Letters D, E, F, U, I, J, P, R, T; indexes without a letter stay blank.
  function automatic logic [SegW-1:0] error_glyph(input logic [ValueW-1:0] idx);
    logic [SegW-1:0] seg;
    case (idx)
      5'd0:    seg = 8'h3A;
      5'd1:    seg = 8'h9E;
      5'd2:    seg = 8'h8E;
      5'd3:    seg = 8'h7C;
      5'd4:    seg = 8'h0C;
      5'd5:    seg = 8'h6C;
      5'd6:    seg = 8'hCE;
      5'd7:    seg = 8'h0A;
      5'd8:    seg = 8'h1E;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

@@ src/status_seven_segment_display_unit.sv @@
// Top level of the status seven-segment digit: error and battery state plus the result register.
`default_nettype none
// Each input beat sets or clears one error bit or loads the battery digit, and the refreshed
// digit is registered and appears on the result channel in the next cycle; one beat is taken every cycle. The
// state update, priority encoder and glyph lookup sit between the state registers and a
// single result register, so the only stall is a result still waiting at the output.
// Beats with an error index at or past NUM_ERRORS, and beats with the unused mode code,
// produce no result. A battery level of 10 or more leaves the digit unchanged but still
// produces a result.
module status_seven_segment_display_unit #(
  parameter int unsigned NUM_ERRORS = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [ssd_pkg::ValueW-1:0]  in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [ssd_pkg::SegW-1:0]    out_segments,
  output logic      [ssd_pkg::NibbleW-1:0] out_port_low,
  output logic      [ssd_pkg::NibbleW-1:0] out_port_high
);

  localparam logic [ssd_pkg::ValueW:0] NumErr = (ssd_pkg::ValueW + 1)'(NUM_ERRORS);

  logic [NUM_ERRORS-1:0]        mask_r, mask_nxt;
  logic [ssd_pkg::DigitW-1:0]   battery_r, battery_nxt;
  logic                         out_valid_r;
  logic [ssd_pkg::SegW-1:0]     seg_r, seg_nxt;
  logic [NUM_ERRORS-1:0]        sel;
  logic                         idx_ok;
  logic                         accept;
  logic                         produce;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = {1'b0, in_value} < NumErr;

  always_comb begin
    for (int unsigned i = 0; i < NUM_ERRORS; i++) begin
      sel[i] = (in_value == ssd_pkg::ValueW'(i));
    end
  end

  always_comb begin
    mask_nxt    = mask_r;
    battery_nxt = battery_r;
    produce     = 1'b0;
    case (in_mode)
      ssd_pkg::MODE_SET_ERROR: begin
        mask_nxt = mask_r | sel;
        produce  = idx_ok;
      end
      ssd_pkg::MODE_CLEAR_ERROR: begin
        mask_nxt = mask_r & ~sel;
        produce  = idx_ok;
      end
      ssd_pkg::MODE_SET_BATTERY: begin
        if (in_value < ssd_pkg::BatteryLimit) begin
          battery_nxt = in_value[ssd_pkg::DigitW-1:0];
        end
        produce = 1'b1;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  ssd_glyph #(
    .NUM_ERRORS(NUM_ERRORS)
  ) u_glyph (
    .error_mask   (mask_nxt),
    .battery_digit(battery_nxt),
    .segments     (seg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      battery_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mask_r    <= mask_nxt;
        battery_r <= battery_nxt;
      end
      if (accept) begin
        out_valid_r <= produce;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_segments  = seg_r;
  assign out_port_low  = {seg_r[0], seg_r[3], seg_r[4], seg_r[5]};
  assign out_port_high = {seg_r[1], seg_r[2], seg_r[7], seg_r[6]};

`ifndef NO_ASSERTIONS
  a_battery_range: assert property (@(posedge clk) disable iff (!rst_n)
    battery_r <= ssd_pkg::DigitW'(9))
    else $error("Battery digit left the range 0 to 9.");

  a_point_without_errors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mask_r == '0) |-> !seg_r[0])
    else $error("Decimal point lit while no error is set.");

  a_unused_mode_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == ssd_pkg::MODE_UNUSED) |=> ($stable(mask_r) && $stable(battery_r)))
    else $error("Beat with the unused mode changed the state.");

  a_no_result_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == ssd_pkg::MODE_UNUSED) |=> !out_valid_r)
    else $error("Beat with the unused mode produced a result.");
`endif

endmodule
`default_nettype wire

@@ src/ssd_glyph.sv @@
// Segment encoder: picks the battery digit or the highest error letter and sets the point.
`default_nettype none
module ssd_glyph #(
  parameter int unsigned NUM_ERRORS = 9
) (
  input  wire logic [NUM_ERRORS-1:0]      error_mask,
  input  wire logic [ssd_pkg::DigitW-1:0] battery_digit,
  output logic      [ssd_pkg::SegW-1:0]   segments
);

  logic [ssd_pkg::ValueW-1:0] top_idx;
  logic                       multi;
  logic [ssd_pkg::SegW-1:0]   base;

  always_comb begin
    top_idx = '0;
    for (int unsigned i = 0; i < NUM_ERRORS; i++) begin
      if (error_mask[i]) begin
        top_idx = ssd_pkg::ValueW'(i);
      end
    end
  end

  assign multi = |(error_mask & (error_mask - NUM_ERRORS'(1)));

  always_comb begin
    if (error_mask == '0) begin
      base = ssd_pkg::digit_glyph(battery_digit);
    end else begin
      base = ssd_pkg::error_glyph(top_idx);
    end
    segments = {base[ssd_pkg::SegW-1:1], base[0] | multi};
  end

endmodule
`default_nettype wire

@@ tb/status_seven_segment_display_unit_test.sv @@
// Testbench for the status digit: directed table, then random beats checked against a predictor.
module status_seven_segment_display_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ErrorCount = 9;
  localparam int RandomBeats = 1527;
  localparam int SettledFrom = 1200;
  localparam int WatchdogLimit = 2000;
  localparam int DirectedRows = 23;
  localparam logic [10*ssd_pkg::SegW-1:0] DigitShapes = {
    8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };
  localparam logic [9*ssd_pkg::SegW-1:0] LetterShapes = {
    8'h1E, 8'h0A, 8'hCE, 8'h6C, 8'h0C, 8'h7C, 8'h8E, 8'h9E, 8'h3A
  };

  typedef struct packed {
    logic [ssd_pkg::SegW-1:0]    segments;
    logic [ssd_pkg::NibbleW-1:0] port_low;
    logic [ssd_pkg::NibbleW-1:0] port_high;
  } digit_view_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_VIEW,
    CHECK_NONE
  } row_check_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [ssd_pkg::ValueW-1:0] value;
    row_check_t                 check;
    digit_view_t                view;
  } stim_row_t;

  localparam digit_view_t NoView = '0;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_mode;
  logic [ssd_pkg::ValueW-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic [ssd_pkg::SegW-1:0] out_segments;
  logic [ssd_pkg::NibbleW-1:0] out_port_low;
  logic [ssd_pkg::NibbleW-1:0] out_port_high;

  logic [ErrorCount-1:0] error_bits;
  logic [ssd_pkg::DigitW-1:0] battery_level;
  digit_view_t pending_views[$];
  stim_row_t directed_rows [0:DirectedRows-1];
  int failures;
  bit settled;

  status_seven_segment_display_unit #(
    .NUM_ERRORS(ErrorCount)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_segments (out_segments),
    .out_port_low (out_port_low),
    .out_port_high(out_port_high)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit predict_digit(input logic [1:0] mode,
                                       input logic [ssd_pkg::ValueW-1:0] value,
                                       output digit_view_t view);
    int count;
    int top;
    logic [ssd_pkg::SegW-1:0] seg;
    view = NoView;
    case (mode)
      ssd_pkg::MODE_SET_ERROR: begin
        if (value >= ErrorCount) return 1'b0;
        error_bits[value] = 1'b1;
      end
      ssd_pkg::MODE_CLEAR_ERROR: begin
        if (value >= ErrorCount) return 1'b0;
        error_bits[value] = 1'b0;
      end
      ssd_pkg::MODE_SET_BATTERY: begin
        if (value < ssd_pkg::BatteryLimit) battery_level = value[ssd_pkg::DigitW-1:0];
      end
      default: return 1'b0;
    endcase
    count = 0;
    top = 0;
    for (int i = 0; i < ErrorCount; i++) begin
      if (error_bits[i]) begin
        count++;
        top = i;
      end
    end
    if (count == 0) seg = DigitShapes[ssd_pkg::SegW*battery_level +: ssd_pkg::SegW];
    else if (top < ssd_pkg::LetterCount) seg = LetterShapes[ssd_pkg::SegW*top +: ssd_pkg::SegW];
    else seg = '0;
    if (count > 1) seg[0] = 1'b1;
    view.segments = seg;
    view.port_low = {seg[0], seg[3], seg[4], seg[5]};
    view.port_high = {seg[1], seg[2], seg[7], seg[6]};
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [1:0] mode, input logic [ssd_pkg::ValueW-1:0] value,
                           input row_check_t check, input digit_view_t typed_view,
                           output bit produced);
    digit_view_t view;
    bit has_view;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_view = predict_digit(mode, value, view);
    if (check == CHECK_VIEW) begin
      has_view = 1'b1;
      view = typed_view;
    end else if (check == CHECK_NONE) begin
      has_view = 1'b0;
    end
    if (has_view) pending_views.push_back(view);
    produced = has_view;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [ssd_pkg::SegW-1:0] expected,
                             input logic [ssd_pkg::SegW-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    digit_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h %h %h", $time,
                 out_segments, out_port_low, out_port_high);
        failures++;
      end else begin
        want = pending_views.pop_front();
        check_field("segments", want.segments, out_segments);
        check_field("port_low", ssd_pkg::SegW'(want.port_low), ssd_pkg::SegW'(out_port_low));
        check_field("port_high", ssd_pkg::SegW'(want.port_high),
                    ssd_pkg::SegW'(out_port_high));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet = 0;
      else quiet++;
    end
    $display("status_seven_segment_display_unit_test failed");
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24)) @(negedge clk);
      if (!settled && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int row;
    int results;
    int beats;
    int set_weight;
    bit sender_idles;
    bit produced;
    int pick;
    logic [1:0] mode;
    logic [ssd_pkg::ValueW-1:0] value;
    in_valid = 1'b0;
    in_mode = ssd_pkg::MODE_SET_ERROR;
    in_value = '0;
    rst_n = 1'b0;
    error_bits = '0;
    battery_level = '0;
    failures = 0;
    settled = 1'b0;
    directed_rows = '{
      '{ssd_pkg::MODE_SET_BATTERY, 5'd0,  CHECK_VIEW,  '{8'hFC, 4'h7, 4'h7}},
      '{ssd_pkg::MODE_SET_BATTERY, 5'd9,  CHECK_VIEW,  '{8'hF6, 4'h3, 4'hF}},
      '{ssd_pkg::MODE_SET_BATTERY, 5'd10, CHECK_VIEW,  '{8'hF6, 4'h3, 4'hF}},
      '{ssd_pkg::MODE_SET_BATTERY, 5'd31, CHECK_VIEW,  '{8'hF6, 4'h3, 4'hF}},
      '{ssd_pkg::MODE_SET_BATTERY, 5'd8,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd0,  CHECK_VIEW,  '{8'h3A, 4'h7, 4'h8}},
      '{ssd_pkg::MODE_SET_ERROR,   5'd8,  CHECK_VIEW,  '{8'h1F, 4'hE, 4'hC}},
      '{ssd_pkg::MODE_SET_ERROR,   5'd9,  CHECK_NONE,  NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd31, CHECK_NONE,  NoView},
      '{ssd_pkg::MODE_CLEAR_ERROR, 5'd31, CHECK_NONE,  NoView},
      '{ssd_pkg::MODE_UNUSED,      5'd0,  CHECK_NONE,  NoView},
      '{ssd_pkg::MODE_UNUSED,      5'd31, CHECK_NONE,  NoView},
      '{ssd_pkg::MODE_CLEAR_ERROR, 5'd8,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd1,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd2,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd3,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd4,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd5,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd6,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_ERROR,   5'd7,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_CLEAR_ERROR, 5'd0,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_CLEAR_ERROR, 5'd7,  CHECK_MODEL, NoView},
      '{ssd_pkg::MODE_SET_BATTERY, 5'd5,  CHECK_MODEL, NoView}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < DirectedRows; row++) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
      send_beat(directed_rows[row].mode, directed_rows[row].value, directed_rows[row].check,
                directed_rows[row].view, produced);
    end

    // Phases lean toward setting or toward clearing so the mask both fills and drains.
    results = 0;
    beats = 0;
    set_weight = 50;
    sender_idles = 1'b1;
    while (beats < RandomBeats) begin
      if (beats % 64 == 0) begin
        set_weight = $urandom_range(10, 75);
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        mode = ssd_pkg::MODE_UNUSED;
        value = ssd_pkg::ValueW'($urandom_range(0, 31));
      end else if (pick < 24) begin
        mode = ssd_pkg::MODE_SET_BATTERY;
        value = ($urandom_range(0, 7) == 0) ? ssd_pkg::ValueW'($urandom_range(10, 31))
                                            : ssd_pkg::ValueW'($urandom_range(0, 9));
      end else begin
        mode = ($urandom_range(0, 99) < set_weight) ? ssd_pkg::MODE_SET_ERROR
                                                    : ssd_pkg::MODE_CLEAR_ERROR;
        value = ($urandom_range(0, 9) == 0)
                ? ssd_pkg::ValueW'($urandom_range(ErrorCount, 31))
                : ssd_pkg::ValueW'($urandom_range(0, ErrorCount - 1));
      end
      if (!settled && sender_idles && $urandom_range(0, 4) == 0)
        pause_sender($urandom_range(1, 9));
      send_beat(mode, value, CHECK_MODEL, NoView, produced);
      beats++;
      if (produced) results++;
      if (results >= SettledFrom) settled = 1'b1;
    end
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0 && pending_views.size() == 0) begin
      $display("status_seven_segment_display_unit_test passed");
    end else begin
      $display("status_seven_segment_display_unit_test failed");
    end
    $finish;
  end

endmodule

@@ status_seven_segment_display_unit.f @@
src/ssd_pkg.sv
src/ssd_glyph.sv
src/status_seven_segment_display_unit.sv
tb/status_seven_segment_display_unit_test.sv
